/* hdl/spcq_pkg.sv */
`timescale 1ns / 1ps
// Package for the strict priority class queue core: defaults, request codes, constants.
// No dependencies.
package spcq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int NUM_CLASSES_DEF = 3;
    localparam int DATA_W          = 32;
    localparam int REQ_W           = 2;

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BOTH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP  = 2'd3;

    localparam logic [DATA_W-1:0] NOTHING_SERVED = {DATA_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

endpackage

/* hdl/strict_priority_class_queues_core.sv */
`timescale 1ns / 1ps
// Top level: NUM_CLASSES bounded FIFO queues in one shared memory, strict priority dequeue.
// Depends on spcq_pkg.
//
// One request is handled at a time: the push write and the head read go to the queue memory in
// the accept cycle, the registered read data (or the forwarded pushed value) is loaded into the
// result register in the next cycle, and the result is then offered in state S_OUT. s_tready
// returns in the cycle after the result is taken, so a request also waits on any hold of
// m_tready before the next request can be taken. Class 0 is the most
// urgent; a class code of NUM_CLASSES or more maps to the least urgent class. A push into a
// full queue is dropped and flagged; a pop with all queues empty flags all_empty and returns -1.
// The queue memory needs no clearing after reset; pointers and fill counts reset to zero.
module strict_priority_class_queues_core #(
    parameter int DEPTH       = spcq_pkg::DEPTH_DEF,
    parameter int NUM_CLASSES = spcq_pkg::NUM_CLASSES_DEF,
    localparam int CLS_W      = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spcq_pkg::DATA_W-1:0]    s_tdata,   // data_in
    input  logic [spcq_pkg::REQ_W+CLS_W-1:0] s_tuser, // req_type, item_class
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spcq_pkg::DATA_W-1:0]    m_tdata,   // data_out
    output logic [CLS_W+2:0]               m_tuser    // enqueue_dropped, served_valid,
                                                      // all_empty, served_class
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRIES = NUM_CLASSES * DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    spcq_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] fill_reg [NUM_CLASSES];
    logic [CNT_W-1:0] fill_next [NUM_CLASSES];
    logic [CNT_W-1:0] fill_pushed [NUM_CLASSES];

    logic [spcq_pkg::DATA_W-1:0] mem [ENTRIES];
    logic [spcq_pkg::DATA_W-1:0] rd_data_reg;

    logic [spcq_pkg::REQ_W-1:0] req_type;
    logic [CLS_W-1:0]           item_class;
    logic [CLS_W-1:0]           cls_eff;
    logic                       is_enq;
    logic                       is_deq;
    logic                       accept;
    logic                       push_ok;
    logic                       pop_found;
    logic [CLS_W-1:0]           pop_cls;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       fill_over;

    logic                        fwd_reg;
    logic [spcq_pkg::DATA_W-1:0] fwd_data_reg;
    logic                        dropped_reg;
    logic                        valid_reg;
    logic                        empty_reg;
    logic [CLS_W-1:0]            class_reg;
    logic                        res_dropped_reg;
    logic                        res_valid_reg;
    logic                        res_empty_reg;
    logic [CLS_W-1:0]            res_class_reg;
    logic [spcq_pkg::DATA_W-1:0] res_data_reg;

    assign req_type   = s_tuser[spcq_pkg::REQ_W-1:0];
    assign item_class = s_tuser[spcq_pkg::REQ_W+CLS_W-1:spcq_pkg::REQ_W];
    assign cls_eff    = ({1'b0, item_class} >= (CLS_W+1)'(NUM_CLASSES))
                        ? CLS_W'(NUM_CLASSES - 1) : item_class;

    assign s_tready = (state_reg == spcq_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_enq = 1'b0;
        is_deq = 1'b0;
        unique case (req_type)
            spcq_pkg::REQ_ENQ:  is_enq = 1'b1;
            spcq_pkg::REQ_DEQ:  is_deq = 1'b1;
            spcq_pkg::REQ_BOTH:
            begin
                is_enq = 1'b1;
                is_deq = 1'b1;
            end
            default:
            begin
                is_enq = 1'b0;
                is_deq = 1'b0;
            end
        endcase
    end

    assign push_ok = is_enq && (fill_reg[cls_eff] != FULL_CNT);

    // queue occupancy as the pop sees it, after this request's push
    always_comb
    begin
        pop_found = 1'b0;
        pop_cls   = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            fill_pushed[c] = fill_reg[c] +
                             CNT_W'(push_ok && (cls_eff == CLS_W'(c)));
            if (!pop_found && (fill_pushed[c] != '0))
            begin
                pop_found = 1'b1;
                pop_cls   = CLS_W'(c);
            end
        end
    end

    assign wr_addr = ADDR_W'(cls_eff) * ADDR_W'(DEPTH) + ADDR_W'(tail_reg[cls_eff]);
    assign rd_addr = ADDR_W'(pop_cls) * ADDR_W'(DEPTH) + ADDR_W'(head_reg[pop_cls]);

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            fill_next[c] = fill_pushed[c];
            if (accept && push_ok && (cls_eff == CLS_W'(c)))
            begin
                tail_next[c] = (tail_reg[c] == LAST_SLOT) ? '0 : tail_reg[c] + 1'b1;
            end
            if (accept && is_deq && pop_found && (pop_cls == CLS_W'(c)))
            begin
                head_next[c] = (head_reg[c] == LAST_SLOT) ? '0 : head_reg[c] + 1'b1;
                fill_next[c] = fill_pushed[c] - 1'b1;
            end
            if (!accept)
            begin
                fill_next[c] = fill_reg[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                fill_reg[c] <= fill_next[c];
            end
        end
    end

    // queue memory: read returns the old word, so a pop of the word pushed in the
    // same request is forwarded
    always_ff @(posedge clk)
    begin
        if (accept && push_ok)
        begin
            mem[wr_addr] <= s_tdata;
        end
        if (accept && is_deq && pop_found)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg      <= push_ok && (pop_cls == cls_eff) && (fill_reg[cls_eff] == '0);
            fwd_data_reg <= s_tdata;
            dropped_reg  <= is_enq && !push_ok;
            valid_reg    <= is_deq && pop_found;
            empty_reg    <= is_deq && !pop_found;
            class_reg    <= (is_deq && pop_found) ? pop_cls : '0;
        end
        if (state_reg == spcq_pkg::S_READ)
        begin
            res_dropped_reg <= dropped_reg;
            res_valid_reg   <= valid_reg;
            res_empty_reg   <= empty_reg;
            res_class_reg   <= class_reg;
            res_data_reg    <= !valid_reg ? spcq_pkg::NOTHING_SERVED :
                               fwd_reg    ? fwd_data_reg : rd_data_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spcq_pkg::S_IDLE: if (accept)   state_next = spcq_pkg::S_READ;
            spcq_pkg::S_READ:               state_next = spcq_pkg::S_OUT;
            spcq_pkg::S_OUT:  if (m_tready) state_next = spcq_pkg::S_IDLE;
            default:                        state_next = spcq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spcq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign m_tvalid = (state_reg == spcq_pkg::S_OUT);
    assign m_tdata  = res_data_reg;
    assign m_tuser  = {res_class_reg, res_empty_reg, res_valid_reg, res_dropped_reg};

    always_comb
    begin
        fill_over = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            fill_over = fill_over || (fill_reg[c] > FULL_CNT);
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) !fill_over)
        else $error("queue fill count above depth");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("new request taken while a result is pending");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result not offered two cycles after request");

    a_served_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("served and all_empty both set");

endmodule
